// ===== design/arpc_pkg.sv =====
`default_nettype none

package arpc_pkg;

  // Default table size and the widths that the interface fixes.
  localparam int TABLE_DEPTH_DEF = 256;
  localparam int IP_W            = 32;
  localparam int MAC_W           = 48;
  localparam int ENTRY_W         = IP_W + MAC_W;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 48;

  // Configuration register indexes. Index one names the station MAC, which
  // the block does not store and no result uses.
  localparam logic [CFG_IDX_W-1:0] REG_OWN_IP = 1'd0;

  // Broadcast destination for an ARP request.
  localparam logic [MAC_W-1:0] MAC_BCAST = {MAC_W{1'b1}};

  // Event codes carried by an input item.
  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_REQ    = 2'd1,
    OP_REPLY  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // Status codes carried by a result item.
  typedef enum logic [2:0] {
    STS_HIT           = 3'd0,
    STS_MISS          = 3'd1,
    STS_REQ_LEARNED   = 3'd2,
    STS_REQ_KNOWN     = 3'd3,
    STS_REPLY_LEARNED = 3'd4,
    STS_CLEARED       = 3'd5,
    STS_FULL          = 3'd6
  } status_t;

  // Frame kinds.
  localparam logic FRAME_REQ   = 1'b0;
  localparam logic FRAME_REPLY = 1'b1;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_SEARCH = 1'b1
  } state_t;

endpackage

`default_nettype wire

// ===== design/arpc_ram.sv =====
`default_nettype none

module arpc_ram #(
  parameter  int WIDTH  = 8,
  parameter  int DEPTH  = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/arp_cache_and_responder.sv =====
`default_nettype none

// A clear, a reply or an item on an empty table gives its result in the cycle
// after acceptance; a lookup or request first scans the table from index zero
// and gives its result at the first match, or after the last entry on a miss.
// Throughput: one item per result; the table is scanned one entry per cycle
// through the single read port of the binding memory. Results cannot be stalled.
// Reset clears the entry count, own IP and control state; memory is not cleared.
module arp_cache_and_responder #(
  parameter int TABLE_DEPTH = arpc_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Configuration port.
  input  wire logic                           cfg_we,
  input  wire logic [arpc_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [arpc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // Command channel.
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [1:0]                     in_op,
  input  wire logic [arpc_pkg::IP_W-1:0]      in_ip,
  input  wire logic [arpc_pkg::MAC_W-1:0]     in_mac,
  input  wire logic [arpc_pkg::IP_W-1:0]      in_target_ip,
  // Result channel.
  output logic                                out_valid,
  output logic [2:0]                          out_status,
  output logic [7:0]                          out_hit_index,
  output logic [arpc_pkg::MAC_W-1:0]          out_hit_mac,
  output logic                                out_send_frame,
  output logic                                out_frame_kind,
  output logic [arpc_pkg::MAC_W-1:0]          out_frame_dest_mac,
  output logic [arpc_pkg::IP_W-1:0]           out_frame_target_ip,
  output logic [arpc_pkg::MAC_W-1:0]          out_frame_target_mac,
  output logic [8:0]                          out_entry_count
);

  import arpc_pkg::*;

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // Control and configuration state.
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [AW-1:0]     rd_addr_r, rd_addr_nxt;
  logic [AW-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic              pend_r, pend_nxt;
  logic [IP_W-1:0]   own_ip_r;

  // Item held during a search.
  op_t               op_r;
  logic [IP_W-1:0]   ip_r;
  logic [MAC_W-1:0]  mac_r;
  logic [IP_W-1:0]   tip_r;

  // Result registers.
  logic              ov_r, ov_nxt;
  status_t           sts_r, sts_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [MAC_W-1:0]  hmac_r, hmac_nxt;
  logic              send_r, send_nxt;
  logic              kind_r, kind_nxt;
  logic [MAC_W-1:0]  dmac_r, dmac_nxt;
  logic [IP_W-1:0]   fip_r, fip_nxt;
  logic [MAC_W-1:0]  fmac_r, fmac_nxt;

  // Memory port signals.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [IP_W-1:0]   rd_ip;
  logic [MAC_W-1:0]  rd_mac;

  // Operands of the item being finished, and the finish request.
  logic              accept;
  op_t               k_op;
  logic [IP_W-1:0]   k_ip;
  logic [MAC_W-1:0]  k_mac;
  logic [IP_W-1:0]   k_tip;
  logic              fin;
  logic              fin_found;
  logic [AW-1:0]     fin_idx;
  logic [MAC_W-1:0]  fin_mac;
  logic              full;
  logic              last_cmp;

  // Binding table: IP in the upper bits, MAC in the lower bits.
  arpc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_bind_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  assign rd_ip  = ram_rdata[ENTRY_W-1:MAC_W];
  assign rd_mac = ram_rdata[MAC_W-1:0];

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign full     = (count_r == CNT_W'(TABLE_DEPTH));
  assign last_cmp = (CNT_W'(cmp_idx_r) == count_r - CNT_W'(1));

  // An idle item is finished straight from the ports; a searched one from
  // the held copy.
  assign k_op  = (state_r == ST_IDLE) ? op_t'(in_op) : op_r;
  assign k_ip  = (state_r == ST_IDLE) ? in_ip        : ip_r;
  assign k_mac = (state_r == ST_IDLE) ? in_mac       : mac_r;
  assign k_tip = (state_r == ST_IDLE) ? in_target_ip : tip_r;

  // Search sequencer. Reads are issued one per cycle and compared in the cycle
  // after, when the data returns. A write only happens on the finishing cycle
  // and the next read comes after a new acceptance, so no forwarding is needed.
  always_comb begin
    state_nxt   = state_r;
    rd_addr_nxt = rd_addr_r;
    cmp_idx_nxt = cmp_idx_r;
    pend_nxt    = pend_r;
    fin         = 1'b0;
    fin_found   = 1'b0;
    fin_idx     = '0;
    fin_mac     = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if ((k_op == OP_LOOKUP || k_op == OP_REQ) && count_r != '0) begin
            state_nxt   = ST_SEARCH;
            rd_addr_nxt = '0;
            pend_nxt    = 1'b0;
          end else begin
            fin = 1'b1;
          end
        end
      end
      ST_SEARCH: begin
        if (rd_addr_r != AW'(TABLE_DEPTH - 1)) begin
          rd_addr_nxt = rd_addr_r + AW'(1);
        end
        cmp_idx_nxt = rd_addr_r;
        pend_nxt    = 1'b1;
        if (pend_r) begin
          if (rd_ip == ip_r) begin
            fin       = 1'b1;
            fin_found = 1'b1;
            fin_idx   = cmp_idx_r;
            fin_mac   = rd_mac;
          end else if (last_cmp) begin
            fin = 1'b1;
          end
        end
        if (fin) begin
          state_nxt = ST_IDLE;
          pend_nxt  = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result formation, table append and count update for a finishing item.
  always_comb begin
    count_nxt = count_r;
    ov_nxt    = fin;
    sts_nxt   = sts_r;
    idx_nxt   = idx_r;
    hmac_nxt  = hmac_r;
    send_nxt  = send_r;
    kind_nxt  = kind_r;
    dmac_nxt  = dmac_r;
    fip_nxt   = fip_r;
    fmac_nxt  = fmac_r;
    ram_we    = 1'b0;
    ram_waddr = count_r[AW-1:0];
    ram_wdata = {k_ip, k_mac};
    if (fin) begin
      idx_nxt  = '0;
      hmac_nxt = '0;
      send_nxt = 1'b0;
      kind_nxt = FRAME_REQ;
      dmac_nxt = '0;
      fip_nxt  = '0;
      fmac_nxt = '0;
      case (k_op)
        OP_LOOKUP: begin
          if (fin_found) begin
            sts_nxt  = STS_HIT;
            idx_nxt  = fin_idx;
            hmac_nxt = fin_mac;
          end else begin
            sts_nxt  = STS_MISS;
            send_nxt = 1'b1;
            dmac_nxt = MAC_BCAST;
            fip_nxt  = k_ip;
          end
        end
        OP_REQ: begin
          if (fin_found) begin
            sts_nxt  = STS_REQ_KNOWN;
            idx_nxt  = fin_idx;
            hmac_nxt = fin_mac;
          end else if (!full) begin
            sts_nxt   = STS_REQ_LEARNED;
            ram_we    = 1'b1;
            idx_nxt   = count_r[AW-1:0];
            hmac_nxt  = k_mac;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            sts_nxt = STS_FULL;
          end
          // A request aimed at this station is answered even when dropped.
          if (k_tip == own_ip_r) begin
            send_nxt = 1'b1;
            kind_nxt = FRAME_REPLY;
            dmac_nxt = k_mac;
            fip_nxt  = k_ip;
            fmac_nxt = k_mac;
          end
        end
        OP_REPLY: begin
          if (!full) begin
            sts_nxt   = STS_REPLY_LEARNED;
            ram_we    = 1'b1;
            idx_nxt   = count_r[AW-1:0];
            hmac_nxt  = k_mac;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            sts_nxt = STS_FULL;
          end
        end
        OP_CLEAR: begin
          sts_nxt   = STS_CLEARED;
          count_nxt = '0;
        end
        default: begin
          sts_nxt = STS_CLEARED;
        end
      endcase
    end
  end

  // Control and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      rd_addr_r <= '0;
      cmp_idx_r <= '0;
      pend_r    <= 1'b0;
      ov_r      <= 1'b0;
      own_ip_r  <= '0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      rd_addr_r <= rd_addr_nxt;
      cmp_idx_r <= cmp_idx_nxt;
      pend_r    <= pend_nxt;
      ov_r      <= ov_nxt;
      if (cfg_we && cfg_addr == REG_OWN_IP) begin
        own_ip_r <= cfg_wdata[IP_W-1:0];
      end
    end
  end

  // Held item and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= op_t'(in_op);
      ip_r  <= in_ip;
      mac_r <= in_mac;
      tip_r <= in_target_ip;
    end
    sts_r  <= sts_nxt;
    idx_r  <= idx_nxt;
    hmac_r <= hmac_nxt;
    send_r <= send_nxt;
    kind_r <= kind_nxt;
    dmac_r <= dmac_nxt;
    fip_r  <= fip_nxt;
    fmac_r <= fmac_nxt;
  end

  // Result ports; index and count carry their low bits for wide tables.
  assign out_valid            = ov_r;
  assign out_status           = sts_r;
  assign out_hit_index        = 8'(idx_r);
  assign out_hit_mac          = hmac_r;
  assign out_send_frame       = send_r;
  assign out_frame_kind       = kind_r;
  assign out_frame_dest_mac   = dmac_r;
  assign out_frame_target_ip  = fip_r;
  assign out_frame_target_mac = fmac_r;
  assign out_entry_count      = 9'(count_r);

`ifndef SYNTHESIS
  // The table never holds more entries than it has rows.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  // A result is only presented once the sequencer has returned to idle.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> !busy)
    else $error("result presented while searching");

  // Every accepted item either finishes at once or starts a search.
  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (ov_r || state_r == ST_SEARCH))
    else $error("accepted item neither finished nor searched");

  // A clear empties the table in its result.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == OP_CLEAR) |=> (ov_r && count_r == '0))
    else $error("clear did not empty the table");

  // The table only grows by one entry at a time.
  a_grow_one: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r > $past(count_r)) |-> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("entry count jumped");
`endif

endmodule

`default_nettype wire

// ===== bench/arp_cache_and_responder_tb.sv =====
`timescale 1ns / 1ps

module arp_cache_and_responder_tb;
  import arpc_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC = 1'd1;
  localparam int IDLE_PCT = 18;
  localparam int POOL_SIZE = 16;
  localparam int MIXED_ITEMS = 180;
  localparam int TRAIL_ITEMS = 60;
  localparam int NUM_PHASES = 6;
  localparam int FILL_PHASE = 3;
  localparam int QUIET_PHASE = 1;
  localparam int DRAIN_LIMIT = 2000;
  localparam int TAIL_CYCLES = 300;
  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    op_t              op;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
    logic [IP_W-1:0]  target_ip;
  } arp_item_t;

  typedef struct packed {
    status_t          status;
    logic [7:0]       hit_index;
    logic [MAC_W-1:0] hit_mac;
    logic             send_frame;
    logic             frame_kind;
    logic [MAC_W-1:0] dest_mac;
    logic [IP_W-1:0]  target_ip;
    logic [MAC_W-1:0] target_mac;
    logic [8:0]       entry_count;
  } arp_result_t;

  typedef struct {
    arp_item_t   item;
    bit          typed;
    arp_result_t result;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic start;
  logic busy;
  logic [1:0] in_op;
  logic [IP_W-1:0] in_ip;
  logic [MAC_W-1:0] in_mac;
  logic [IP_W-1:0] in_target_ip;
  logic out_valid;
  logic [2:0] out_status;
  logic [7:0] out_hit_index;
  logic [MAC_W-1:0] out_hit_mac;
  logic out_send_frame;
  logic out_frame_kind;
  logic [MAC_W-1:0] out_frame_dest_mac;
  logic [IP_W-1:0] out_frame_target_ip;
  logic [MAC_W-1:0] out_frame_target_mac;
  logic [8:0] out_entry_count;

  // Shadow copy of the binding table and the station registers.
  logic [IP_W-1:0]  shadow_ip  [DEPTH];
  logic [MAC_W-1:0] shadow_mac [DEPTH];
  int unsigned      shadow_count;
  logic [IP_W-1:0]  station_ip;
  logic [MAC_W-1:0] station_mac;

  arp_result_t awaited_results[$];
  stim_row_t directed_rows[$];
  logic [IP_W-1:0] ip_pool [POOL_SIZE];
  bit idle_on;

  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int hits_seen = 0;
  int misses_seen = 0;
  int full_seen = 0;
  int replies_seen = 0;
  int clears_seen = 0;

  arp_cache_and_responder dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_addr             (cfg_addr),
    .cfg_wdata            (cfg_wdata),
    .start                (start),
    .busy                 (busy),
    .in_op                (in_op),
    .in_ip                (in_ip),
    .in_mac               (in_mac),
    .in_target_ip         (in_target_ip),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_hit_index        (out_hit_index),
    .out_hit_mac          (out_hit_mac),
    .out_send_frame       (out_send_frame),
    .out_frame_kind       (out_frame_kind),
    .out_frame_dest_mac   (out_frame_dest_mac),
    .out_frame_target_ip  (out_frame_target_ip),
    .out_frame_target_mac (out_frame_target_mac),
    .out_entry_count      (out_entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The run is cut off here if the block stops answering.
  initial begin
    #20_000_000;
    $display("Timeout: %0d results still outstanding.", awaited_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTED) begin
      $display("MISMATCH at %0t: %s", $time, msg);
    end
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
    end
  endtask

  function automatic arp_result_t make_result(
      input status_t status, input logic [7:0] idx, input logic [MAC_W-1:0] hmac,
      input logic send, input logic kind, input logic [MAC_W-1:0] dmac,
      input logic [IP_W-1:0] fip, input logic [MAC_W-1:0] fmac, input logic [8:0] count);
    arp_result_t r;
    r.status      = status;
    r.hit_index   = idx;
    r.hit_mac     = hmac;
    r.send_frame  = send;
    r.frame_kind  = kind;
    r.dest_mac    = dmac;
    r.target_ip   = fip;
    r.target_mac  = fmac;
    r.entry_count = count;
    return r;
  endfunction

  // Appends a binding to the shadow table; returns 0 when it is full.
  function automatic bit shadow_append(input logic [IP_W-1:0] ip,
                                       input logic [MAC_W-1:0] mac);
    if (shadow_count >= DEPTH) begin
      return 1'b0;
    end
    shadow_ip[shadow_count]  = ip;
    shadow_mac[shadow_count] = mac;
    shadow_count++;
    return 1'b1;
  endfunction

  // Works out the result of one item and updates the shadow table.
  function automatic arp_result_t arp_resolve(input arp_item_t it);
    arp_result_t r;
    int found;
    int k;
    r = '0;
    found = -1;
    for (k = 0; k < int'(shadow_count); k++) begin
      if (found < 0 && shadow_ip[k] == it.ip) begin
        found = k;
      end
    end
    case (it.op)
      OP_LOOKUP: begin
        if (found >= 0) begin
          r.status    = STS_HIT;
          r.hit_index = 8'(found);
          r.hit_mac   = shadow_mac[found];
        end else begin
          r.status     = STS_MISS;
          r.send_frame = 1'b1;
          r.frame_kind = FRAME_REQ;
          r.dest_mac   = MAC_BCAST;
          r.target_ip  = it.ip;
        end
      end
      OP_REQ: begin
        if (found >= 0) begin
          r.status    = STS_REQ_KNOWN;
          r.hit_index = 8'(found);
          r.hit_mac   = shadow_mac[found];
        end else if (shadow_append(it.ip, it.mac)) begin
          r.status    = STS_REQ_LEARNED;
          r.hit_index = 8'(shadow_count - 1);
          r.hit_mac   = it.mac;
        end else begin
          r.status = STS_FULL;
        end
        // A request aimed at this station is answered even when it is not learned.
        if (it.target_ip == station_ip) begin
          r.send_frame = 1'b1;
          r.frame_kind = FRAME_REPLY;
          r.dest_mac   = it.mac;
          r.target_ip  = it.ip;
          r.target_mac = it.mac;
        end
      end
      OP_REPLY: begin
        if (shadow_append(it.ip, it.mac)) begin
          r.status    = STS_REPLY_LEARNED;
          r.hit_index = 8'(shadow_count - 1);
          r.hit_mac   = it.mac;
        end else begin
          r.status = STS_FULL;
        end
      end
      default: begin
        shadow_count = 0;
        r.status = STS_CLEARED;
      end
    endcase
    r.entry_count = 9'(shadow_count);
    return r;
  endfunction

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 15))
      0: w = '0;
      1: w = '1;
      default: ;
    endcase
    return w[MAC_W-1:0];
  endfunction

  function automatic logic [IP_W-1:0] pick_ip();
    if ($urandom_range(0, 9) < 7) begin
      return ip_pool[$urandom_range(0, POOL_SIZE - 1)];
    end
    return $urandom;
  endfunction

  // A random event drawn mostly from a small address pool so that hits occur.
  function automatic arp_item_t rand_item();
    arp_item_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < 36) begin
      it.op = OP_LOOKUP;
    end else if (r < 66) begin
      it.op = OP_REQ;
    end else if (r < 92) begin
      it.op = OP_REPLY;
    end else begin
      it.op = OP_CLEAR;
    end
    it.ip = pick_ip();
    it.mac = rand_mac();
    it.target_ip = ($urandom_range(0, 1) == 1) ? station_ip : pick_ip();
    return it;
  endfunction

  task automatic add_row(input op_t op, input logic [IP_W-1:0] ip,
                         input logic [MAC_W-1:0] mac, input logic [IP_W-1:0] tip,
                         input bit typed, input arp_result_t res);
    stim_row_t row;
    row.item.op = op;
    row.item.ip = ip;
    row.item.mac = mac;
    row.item.target_ip = tip;
    row.typed = typed;
    row.result = res;
    directed_rows.push_back(row);
  endtask

  // Offers one item, waits until it is taken and records what should come back.
  task automatic send_item(input arp_item_t it, input bit typed,
                           input arp_result_t typed_result);
    arp_result_t predicted;
    if (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start        <= 1'b1;
    in_op        <= it.op;
    in_ip        <= it.ip;
    in_mac       <= it.mac;
    in_target_ip <= it.target_ip;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = arp_resolve(it);
    awaited_results.push_back(typed ? typed_result : predicted);
    items_sent++;
  endtask

  // Holds off new items until every result is in and the block is idle.
  task automatic settle();
    int guard;
    guard = 0;
    start <= 1'b0;
    do begin
      @(posedge clk);
      guard++;
    end while ((awaited_results.size() != 0 || busy) && guard < DRAIN_LIMIT);
  endtask

  // Register writes happen back to back while the block is idle.
  task automatic set_station(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_OWN_IP;
    cfg_wdata <= CFG_DATA_W'(ip);
    @(posedge clk);
    cfg_addr  <= REG_OWN_MAC;
    cfg_wdata <= mac;
    @(posedge clk);
    cfg_we <= 1'b0;
    station_ip  = ip;
    station_mac = mac;
  endtask

  task automatic refill_pool();
    int k;
    ip_pool[0] = station_ip;
    ip_pool[1] = '0;
    ip_pool[2] = '1;
    for (k = 3; k < POOL_SIZE; k++) begin
      ip_pool[k] = $urandom;
    end
  endtask

  // Fills the table with distinct senders, then keeps pushing into the full table.
  task automatic run_fill();
    arp_item_t it;
    logic [IP_W-1:0] base;
    int k;
    base = $urandom;
    it = '0;
    it.op = OP_CLEAR;
    send_item(it, 1'b0, '0);
    for (k = 0; k < DEPTH; k++) begin
      it.op = ($urandom_range(0, 1) == 1) ? OP_REQ : OP_REPLY;
      it.ip = base + k;
      it.mac = rand_mac();
      it.target_ip = ($urandom_range(0, 1) == 1) ? station_ip : $urandom;
      send_item(it, 1'b0, '0);
    end
    for (k = 0; k < TRAIL_ITEMS; k++) begin
      it = rand_item();
      if (it.op == OP_CLEAR) begin
        it.op = OP_REPLY;
      end
      if ($urandom_range(0, 1) == 1) begin
        it.ip = base + $urandom_range(0, DEPTH - 1);
      end
      send_item(it, 1'b0, '0);
    end
  endtask

  // Checks every result against the oldest outstanding expectation.
  always @(posedge clk) begin
    arp_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        report_mismatch("result arrived with no item outstanding");
      end else begin
        want = awaited_results.pop_front();
        check_field("status", out_status, want.status);
        check_field("hit_index", out_hit_index, want.hit_index);
        check_field("hit_mac", out_hit_mac, want.hit_mac);
        check_field("send_frame", out_send_frame, want.send_frame);
        check_field("frame_kind", out_frame_kind, want.frame_kind);
        check_field("frame_dest_mac", out_frame_dest_mac, want.dest_mac);
        check_field("frame_target_ip", out_frame_target_ip, want.target_ip);
        check_field("frame_target_mac", out_frame_target_mac, want.target_mac);
        check_field("entry_count", out_entry_count, want.entry_count);
        if (want.status == STS_HIT) hits_seen++;
        if (want.status == STS_MISS) misses_seen++;
        if (want.status == STS_FULL) full_seen++;
        if (want.status == STS_CLEARED) clears_seen++;
        if (want.send_frame && want.frame_kind == FRAME_REPLY) replies_seen++;
      end
    end
  end

  initial begin
    int p;
    int k;
    logic [IP_W-1:0] new_ip;
    logic [MAC_W-1:0] new_mac;
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_addr     <= '0;
    cfg_wdata    <= '0;
    start        <= 1'b0;
    in_op        <= '0;
    in_ip        <= '0;
    in_mac       <= '0;
    in_target_ip <= '0;
    shadow_count = 0;
    station_ip   = '0;
    station_mac  = '0;
    idle_on      = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed events at the reset station address of zero.
    add_row(OP_LOOKUP, 32'h0, 48'h0, 32'h0, 1'b1,
            make_result(STS_MISS, 8'd0, '0, 1'b1, FRAME_REQ, MAC_BCAST, 32'h0, '0, 9'd0));
    add_row(OP_LOOKUP, '1, '1, '1, 1'b1,
            make_result(STS_MISS, 8'd0, '0, 1'b1, FRAME_REQ, MAC_BCAST, '1, '0, 9'd0));
    add_row(OP_REPLY, 32'h0, 48'h0, 32'h0, 1'b1,
            make_result(STS_REPLY_LEARNED, 8'd0, '0, 1'b0, 1'b0, '0, '0, '0, 9'd1));
    add_row(OP_REPLY, '1, '1, '1, 1'b1,
            make_result(STS_REPLY_LEARNED, 8'd1, '1, 1'b0, 1'b0, '0, '0, '0, 9'd2));
    add_row(OP_LOOKUP, '1, 48'h0, 32'h0, 1'b1,
            make_result(STS_HIT, 8'd1, '1, 1'b0, 1'b0, '0, '0, '0, 9'd2));
    add_row(OP_LOOKUP, 32'h0, '1, '1, 1'b1,
            make_result(STS_HIT, 8'd0, '0, 1'b0, 1'b0, '0, '0, '0, 9'd2));
    // A reply may duplicate an address; lookups still find the lowest index.
    add_row(OP_REPLY, '1, 48'h1234_5678_9abc, 32'h0, 1'b1,
            make_result(STS_REPLY_LEARNED, 8'd2, 48'h1234_5678_9abc, 1'b0, 1'b0,
                        '0, '0, '0, 9'd3));
    add_row(OP_LOOKUP, '1, 48'h0, 32'h0, 1'b1,
            make_result(STS_HIT, 8'd1, '1, 1'b0, 1'b0, '0, '0, '0, 9'd3));
    add_row(OP_REQ, 32'h0a00_0001, 48'haabb_ccdd_eeff, 32'h0, 1'b1,
            make_result(STS_REQ_LEARNED, 8'd3, 48'haabb_ccdd_eeff, 1'b1, FRAME_REPLY,
                        48'haabb_ccdd_eeff, 32'h0a00_0001, 48'haabb_ccdd_eeff, 9'd4));
    add_row(OP_REQ, 32'h0a00_0001, 48'h1111_1111_1111, 32'h0a00_00fe, 1'b1,
            make_result(STS_REQ_KNOWN, 8'd3, 48'haabb_ccdd_eeff, 1'b0, 1'b0,
                        '0, '0, '0, 9'd4));
    add_row(OP_REQ, 32'h0a00_0002, 48'h0200_0000_0002, 32'h1234_5678, 1'b0, '0);
    add_row(OP_REQ, '1, 48'h5a5a_a5a5_5a5a, 32'h0, 1'b0, '0);
    add_row(OP_LOOKUP, 32'h0a00_0002, 48'h0, 32'h0, 1'b0, '0);
    add_row(OP_LOOKUP, 32'h0a00_0003, 48'h0, 32'h0, 1'b0, '0);
    add_row(OP_REPLY, 32'h0a00_0003, 48'h0300_0000_0003, 32'h0, 1'b0, '0);
    add_row(OP_CLEAR, 32'h0, 48'h0, 32'h0, 1'b1,
            make_result(STS_CLEARED, 8'd0, '0, 1'b0, 1'b0, '0, '0, '0, 9'd0));
    add_row(OP_LOOKUP, 32'h0a00_0001, 48'h0, 32'h0, 1'b1,
            make_result(STS_MISS, 8'd0, '0, 1'b1, FRAME_REQ, MAC_BCAST,
                        32'h0a00_0001, '0, 9'd0));
    add_row(OP_REQ, 32'h0a00_0001, 48'h0000_0000_0001, '1, 1'b0, '0);
    add_row(OP_CLEAR, '1, '1, '1, 1'b1,
            make_result(STS_CLEARED, 8'd0, '0, 1'b0, 1'b0, '0, '0, '0, 9'd0));
    add_row(OP_CLEAR, 32'h0, 48'h0, 32'h0, 1'b1,
            make_result(STS_CLEARED, 8'd0, '0, 1'b0, 1'b0, '0, '0, '0, 9'd0));
    add_row(OP_LOOKUP, 32'h0a00_0001, '1, '1, 1'b1,
            make_result(STS_MISS, 8'd0, '0, 1'b1, FRAME_REQ, MAC_BCAST,
                        32'h0a00_0001, '0, 9'd0));
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);
    end
    settle();

    // Random phases, each under a new station address; one fills the table.
    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          new_ip  = '1;
          new_mac = '1;
        end
        1: begin
          new_ip  = '0;
          new_mac = '0;
        end
        default: begin
          new_ip  = $urandom;
          new_mac = rand_mac();
        end
      endcase
      set_station(new_ip, new_mac);
      refill_pool();
      idle_on = (p != QUIET_PHASE);
      if (p == FILL_PHASE) begin
        run_fill();
      end else begin
        for (k = 0; k < MIXED_ITEMS; k++) begin
          send_item(rand_item(), 1'b0, '0);
        end
      end
      settle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
    end
    $display("Summary: %0d items sent, %0d results checked, %0d hits, %0d misses.",
             items_sent, results_seen, hits_seen, misses_seen);
    $display("Summary: %0d drops on a full table, %0d replies sent, %0d clears, %0d errors.",
             full_seen, replies_seen, clears_seen, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/arpc_pkg.sv
design/arpc_ram.sv
design/arp_cache_and_responder.sv
bench/arp_cache_and_responder_tb.sv
